### hdl/urmt_pkg.sv
// Shared types, field widths and helper functions for the UDP rule match rate trigger.
package urmt_pkg;

    // Field widths of the request and result items.
    localparam int SLOT_W   = 4;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int NEG_W    = 4;
    localparam int CNT_W    = 16;
    localparam int WIN_W    = 16;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 5;
    localparam int MASK_W   = 16;
    localparam int TDATA_W  = 168;
    localparam int TUSER_W  = 1;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Request kinds carried on tuser.
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_PACKET = 1'b1;

    // Bit positions in the negate mask.
    localparam int NEG_SRC_IP   = 0;
    localparam int NEG_DST_IP   = 1;
    localparam int NEG_DST_PORT = 2;
    localparam int NEG_SRC_PORT = 3;

    // Saturation value of the per-rule hit counter.
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Layout of s_tdata; the last member sits in the lowest bits.
    typedef struct packed {
        logic [TIME_W-1:0] now_seconds;
        logic [WIN_W-1:0]  window_seconds;
        logic [CNT_W-1:0]  threshold;
        logic [NEG_W-1:0]  negate_mask;
        logic [PORT_W-1:0] dst_port;
        logic [PORT_W-1:0] src_port;
        logic [ADDR_W-1:0] dst_ip;
        logic [ADDR_W-1:0] src_ip;
        logic [SLOT_W-1:0] slot;
    } tdata_t;

    // A classified request as it travels from the front to the back part.
    typedef struct packed {
        logic   is_packet;
        tdata_t fields;
    } req_t;

    // One rule field test: zero in the rule is a wildcard, else an
    // equality test that may be inverted.
    function automatic logic field_ok(input logic [ADDR_W-1:0] rule_val,
                                      input logic [ADDR_W-1:0] pkt_val,
                                      input logic negated);
        logic ok;
        if (rule_val == '0) begin
            ok = 1'b1;
        end else if (negated) begin
            ok = (rule_val != pkt_val);
        end else begin
            ok = (rule_val == pkt_val);
        end
        return ok;
    endfunction

endpackage

### hdl/urmt_queue.sv
// Short request queue that decouples the front part from the back part.
module urmt_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  urmt_pkg::req_t   push_req,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output urmt_pkg::req_t   pop_req
);

    localparam int DEPTH = urmt_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    urmt_pkg::req_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_req   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

### hdl/urmt_front.sv
// Front part: accepts requests, classifies them and hands them to the queue.
module urmt_front #(
    parameter int RULE_SLOTS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [urmt_pkg::TDATA_W-1:0]  s_tdata,
    input  logic [urmt_pkg::TUSER_W-1:0]  s_tuser,
    output logic                          q_push,
    output urmt_pkg::req_t                q_req,
    input  logic                          q_full
);

    urmt_pkg::tdata_t fields;
    urmt_pkg::req_t   req_reg;
    logic             valid_reg, valid_next;
    logic             accept;
    logic             is_packet;
    logic             keep;

    assign fields    = urmt_pkg::tdata_t'(s_tdata);
    assign is_packet = (s_tuser[0] == urmt_pkg::KIND_PACKET);

    // A load aimed beyond the rule table is dropped here.
    assign keep = is_packet || (int'(fields.slot) < RULE_SLOTS);

    assign q_push   = valid_reg && !q_full;
    assign s_tready = !valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_req    = req_reg;

    // The stage holds one request until the queue takes it.
    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = keep;
        end else if (q_push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg.is_packet <= is_packet;
            req_reg.fields    <= fields;
        end
    end

endmodule

### hdl/urmt_back.sv
// Back part: rule table with one match and rate cell per slot, and the result register.
module urmt_back #(
    parameter int RULE_SLOTS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [urmt_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          q_valid,
    input  urmt_pkg::req_t                q_req,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [urmt_pkg::MASK_W-1:0]   m_tdata
);

    localparam int SLOT_W = urmt_pkg::SLOT_W;
    localparam int ADDR_W = urmt_pkg::ADDR_W;
    localparam int PORT_W = urmt_pkg::PORT_W;
    localparam int CNT_W  = urmt_pkg::CNT_W;
    localparam int WIN_W  = urmt_pkg::WIN_W;
    localparam int TIME_W = urmt_pkg::TIME_W;
    localparam int MASK_W = urmt_pkg::MASK_W;

    logic [urmt_pkg::CFG_W-1:0] rules_in_use_reg;

    // Rule contents; undefined until loaded.
    logic [ADDR_W-1:0]         rule_src_reg   [RULE_SLOTS];
    logic [ADDR_W-1:0]         rule_dst_reg   [RULE_SLOTS];
    logic [PORT_W-1:0]         rule_sport_reg [RULE_SLOTS];
    logic [PORT_W-1:0]         rule_dport_reg [RULE_SLOTS];
    logic [urmt_pkg::NEG_W-1:0] rule_neg_reg  [RULE_SLOTS];
    logic [CNT_W-1:0]          rule_thr_reg   [RULE_SLOTS];
    logic [WIN_W-1:0]          rule_win_reg   [RULE_SLOTS];

    // Rate state; cleared by reset.
    logic [TIME_W-1:0]         start_reg [RULE_SLOTS];
    logic [RULE_SLOTS-1:0]     idle_reg;
    logic [CNT_W-1:0]          cnt_reg   [RULE_SLOTS];

    logic [RULE_SLOTS-1:0]     fired;
    logic [MASK_W-1:0]         mask;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [MASK_W-1:0]         m_tdata_reg;
    logic                      pkt_go;
    logic                      load_go;
    urmt_pkg::tdata_t          f;

    assign f       = q_req.fields;
    assign q_pop   = q_valid && (!q_req.is_packet || !m_tvalid_reg || m_tready);
    assign pkt_go  = q_pop && q_req.is_packet;
    assign load_go = q_pop && !q_req.is_packet;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rules_in_use_reg <= '0;
        end else if (cfg_wr_en) begin
            rules_in_use_reg <= cfg_wr_data;
        end
    end

    // One cell per rule slot.
    for (genvar i = 0; i < RULE_SLOTS; i++) begin : g_cell
        logic              load_we;
        logic              active;
        logic              match;
        logic              hit;
        logic              expired;
        logic [TIME_W:0]   end_time;
        logic [CNT_W-1:0]  cnt_inc;
        logic              idle_next;
        logic [TIME_W-1:0] start_next;
        logic [CNT_W-1:0]  cnt_next;
        logic              fire;

        if (i < (1 << SLOT_W)) begin : g_addr
            assign load_we = load_go && (f.slot == SLOT_W'(i));
        end else begin : g_noaddr
            assign load_we = 1'b0;
        end

        // Match test, window check and counter update.
        always_comb begin
            active = (i < int'(rules_in_use_reg));
            match  = urmt_pkg::field_ok(rule_src_reg[i], f.src_ip,
                                        rule_neg_reg[i][urmt_pkg::NEG_SRC_IP])
                  && urmt_pkg::field_ok(rule_dst_reg[i], f.dst_ip,
                                        rule_neg_reg[i][urmt_pkg::NEG_DST_IP])
                  && urmt_pkg::field_ok(ADDR_W'(rule_dport_reg[i]), ADDR_W'(f.dst_port),
                                        rule_neg_reg[i][urmt_pkg::NEG_DST_PORT])
                  && urmt_pkg::field_ok(ADDR_W'(rule_sport_reg[i]), ADDR_W'(f.src_port),
                                        rule_neg_reg[i][urmt_pkg::NEG_SRC_PORT]);
            hit      = pkt_go && active && match;
            end_time = {1'b0, start_reg[i]} + (TIME_W + 1)'(rule_win_reg[i]);
            expired  = (end_time <= {1'b0, f.now_seconds});
            cnt_inc  = (cnt_reg[i] == urmt_pkg::CNT_MAX) ? cnt_reg[i]
                                                         : cnt_reg[i] + CNT_W'(1);
            idle_next  = idle_reg[i];
            start_next = start_reg[i];
            cnt_next   = cnt_reg[i];
            fire       = 1'b0;
            if (load_we) begin
                idle_next  = 1'b1;
                start_next = '0;
                cnt_next   = '0;
            end else if (hit) begin
                if (!idle_reg[i] && expired) begin
                    // Expired window re-arms the rule without counting.
                    idle_next = 1'b1;
                end else begin
                    if (idle_reg[i]) begin
                        idle_next  = 1'b0;
                        start_next = f.now_seconds;
                    end
                    if (rule_thr_reg[i] <= cnt_inc) begin
                        cnt_next  = '0;
                        idle_next = 1'b1;
                        fire      = 1'b1;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
            end
        end

        assign fired[i] = fire;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                idle_reg[i]  <= 1'b1;
                start_reg[i] <= '0;
                cnt_reg[i]   <= '0;
            end else begin
                idle_reg[i]  <= idle_next;
                start_reg[i] <= start_next;
                cnt_reg[i]   <= cnt_next;
            end
        end

        always_ff @(posedge aclk) begin
            if (load_we) begin
                rule_src_reg[i]   <= f.src_ip;
                rule_dst_reg[i]   <= f.dst_ip;
                rule_sport_reg[i] <= f.src_port;
                rule_dport_reg[i] <= f.dst_port;
                rule_neg_reg[i]   <= f.negate_mask;
                rule_thr_reg[i]   <= f.threshold;
                rule_win_reg[i]   <= f.window_seconds;
            end
        end
    end

    // Slots beyond the mask width are matched but not reported.
    for (genvar j = 0; j < MASK_W; j++) begin : g_mask
        if (j < RULE_SLOTS) begin : g_used
            assign mask[j] = fired[j];
        end else begin : g_unused
            assign mask[j] = 1'b0;
        end
    end

    // Result register.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (pkt_go) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pkt_go) begin
            m_tdata_reg <= mask;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### hdl/udp_rule_match_rate_trigger_core.sv
// Top level of the UDP rule match rate trigger.
//
// Requests enter on the s_ channel. s_tuser selects the kind: a load writes
// one rule into the slot named in s_tdata, a packet carries header fields and
// the current seconds and is checked against every rule slot below
// rules_in_use at once, one match and rate cell per slot.
// Each packet yields one result on the m_ channel, the mask of rules that
// fired; loads yield none. cfg_wr_en with cfg_wr_data sets rules_in_use.
// A request passes an input stage, a two-entry queue and the rule cells;
// one request per cycle is taken for as long as the result side keeps up.
// The rule cells update all slots in the single cycle a request leaves the
// queue.
// While m_tready is low a valid result stays in the result register, loads
// at the queue head still drain, and the queue and input stage fill before s_tready drops.
// Reset clears the queue, the result register, rules_in_use and the window
// and hit state of every rule; rule contents are undefined until loaded.
module udp_rule_match_rate_trigger_core #(
    parameter int RULE_SLOTS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: rules_in_use.
    input  logic                          cfg_wr_en,
    input  logic [urmt_pkg::CFG_W-1:0]    cfg_wr_data,
    // Request channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // slot[3:0], src_ip[35:4], dst_ip[67:36], src_port[83:68], dst_port[99:84],
    // negate_mask[103:100], threshold[119:104], window_seconds[135:120],
    // now_seconds[167:136]
    input  logic [urmt_pkg::TDATA_W-1:0]  s_tdata,
    // kind[0]
    input  logic [urmt_pkg::TUSER_W-1:0]  s_tuser,
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // fired_mask[15:0]
    output logic [urmt_pkg::MASK_W-1:0]   m_tdata
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    urmt_pkg::req_t push_req;
    urmt_pkg::req_t pop_req;

    urmt_front #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_req    (push_req),
        .q_full   (q_full)
    );

    urmt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_req  (push_req),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_req   (pop_req)
    );

    urmt_back #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_req       (pop_req),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

### hdl/urmt_checker.sv
// Port-level assertions for the UDP rule match rate trigger, bound to the top level.
module urmt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [urmt_pkg::MASK_W-1:0]   m_tdata
);

    // A result held back by the receiver stays and keeps its value.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Reset empties the result register and opens the request side.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not empty after reset");

    // A cycle with the receiver ready drains the queue enough to take a request.
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(m_tready) |-> s_tready)
        else $error("request side stalled although results were taken");

endmodule

bind udp_rule_match_rate_trigger_core urmt_checker u_urmt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
